@@ src/bts_pkg.sv @@
package bts_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_VERTEX_A = 3'd0;
  localparam logic [2:0] REG_VERTEX_B = 3'd1;
  localparam logic [2:0] REG_VERTEX_C = 3'd2;
  localparam logic [2:0] REG_COLOR_A  = 3'd3;
  localparam logic [2:0] REG_COLOR_B  = 3'd4;
  localparam logic [2:0] REG_COLOR_C  = 3'd5;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COLOR_W    = 3 * CHAN_W;
  localparam int unsigned DIV_STEPS  = CHAN_W;
  // Setup, products, sums, normalize, color products, color sums,
  // one stage per quotient bit, output register
  localparam int unsigned PIPE_DEPTH = 6 + DIV_STEPS + 1;
  localparam logic [CHAN_W-1:0] CHAN_WHITE = '1;

endpackage

@@ src/barycentric_triangle_shader_unit.sv @@
// Channel   | Handshake           | Payload
// ----------+---------------------+-------------------------------------------
// pixel in  | start_i / busy_o    | pixel_x_i, pixel_y_i
// result    | valid_o (strobe)    | red_o, green_o, blue_o, inside_res_o
// config    | cfg_we_i, cfg_idx_i | cfg_data_i
//
// One pixel a cycle; busy_o stays low. Each result passes through six
// arithmetic stages, then one restoring divider stage per quotient bit,
// then the output register.
// Reset clears the configuration registers and the valid pipe. The receiver cannot stall;
// valid_o strobes for one cycle per result.
module barycentric_triangle_shader_unit
  import bts_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic signed [COORD_BITS-1:0] pixel_x_i,
  input  logic signed [COORD_BITS-1:0] pixel_y_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [((2*COORD_BITS > COLOR_W) ? 2*COORD_BITS : COLOR_W)-1:0] cfg_data_i,
  output logic                  valid_o,
  output logic [CHAN_W-1:0]     red_o,
  output logic [CHAN_W-1:0]     green_o,
  output logic [CHAN_W-1:0]     blue_o,
  output logic                  inside_res_o
);

  localparam int unsigned VW = 2 * COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 1;     // coordinate difference
  localparam int unsigned PW = 2 * DW;             // product
  localparam int unsigned SW = PW + 1;             // numerator / denominator
  localparam int unsigned NW = SW;                 // normalized magnitude
  localparam int unsigned MW = NW + CHAN_W;        // weight times channel
  localparam int unsigned RW = NW + CHAN_W + 2;    // channel sum, remainder

  logic          accept;
  logic [PIPE_DEPTH-1:0] vld_q;

  logic [VW-1:0]      va_q, vb_q, vc_q;
  logic [COLOR_W-1:0] ca_q, cb_q, cc_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vb_q <= '0;
      vc_q <= '0;
      ca_q <= '0;
      cb_q <= '0;
      cc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VERTEX_A: va_q <= cfg_data_i[VW-1:0];
        REG_VERTEX_B: vb_q <= cfg_data_i[VW-1:0];
        REG_VERTEX_C: vc_q <= cfg_data_i[VW-1:0];
        REG_COLOR_A:  ca_q <= cfg_data_i[COLOR_W-1:0];
        REG_COLOR_B:  cb_q <= cfg_data_i[COLOR_W-1:0];
        REG_COLOR_C:  cc_q <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
    end
  end

  // Stage 1: coordinate differences
  logic signed [DW-1:0] x1, y1, x2, y2, x3, y3, px, py;
  assign x1 = {va_q[VW-1], va_q[VW-1:COORD_BITS]};
  assign y1 = {va_q[COORD_BITS-1], va_q[COORD_BITS-1:0]};
  assign x2 = {vb_q[VW-1], vb_q[VW-1:COORD_BITS]};
  assign y2 = {vb_q[COORD_BITS-1], vb_q[COORD_BITS-1:0]};
  assign x3 = {vc_q[VW-1], vc_q[VW-1:COORD_BITS]};
  assign y3 = {vc_q[COORD_BITS-1], vc_q[COORD_BITS-1:0]};
  assign px = {pixel_x_i[COORD_BITS-1], pixel_x_i};
  assign py = {pixel_y_i[COORD_BITS-1], pixel_y_i};

  logic signed [DW-1:0] dy23_q, dx32_q, dy31_q, dx13_q, dy13_q, dpx_q, dpy_q;
  always_ff @(posedge clk_i) begin
    dy23_q <= y2 - y3;
    dx32_q <= x3 - x2;
    dy31_q <= y3 - y1;
    dx13_q <= x1 - x3;
    dy13_q <= y1 - y3;
    dpx_q  <= px - x3;
    dpy_q  <= py - y3;
  end

  // Stage 2: cross products
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, q1_q, q2_q;
  always_ff @(posedge clk_i) begin
    p1_q <= dy23_q * dpx_q;
    p2_q <= dx32_q * dpy_q;
    p3_q <= dy31_q * dpx_q;
    p4_q <= dx13_q * dpy_q;
    q1_q <= dy23_q * dx13_q;
    q2_q <= dx32_q * dy13_q;
  end

  // Stage 3: numerators and denominator
  logic signed [SW-1:0] n1_q, n2_q, den_s_q;
  always_ff @(posedge clk_i) begin
    n1_q    <= {p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q};
    n2_q    <= {p3_q[PW-1], p3_q} + {p4_q[PW-1], p4_q};
    den_s_q <= {q1_q[PW-1], q1_q} + {q2_q[PW-1], q2_q};
  end

  // Stage 4: make the denominator positive, derive the third weight and the inside flag
  logic signed [SW+2:0] dn, n1n, n2n, n3n;
  logic                 in_d;
  always_comb begin
    dn  = {{3{den_s_q[SW-1]}}, den_s_q};
    n1n = {{3{n1_q[SW-1]}}, n1_q};
    n2n = {{3{n2_q[SW-1]}}, n2_q};
    if (den_s_q[SW-1]) begin
      dn  = -dn;
      n1n = -n1n;
      n2n = -n2n;
    end
    n3n  = dn - n1n - n2n;
    in_d = (dn != '0) && !n1n[SW+2] && !n2n[SW+2] && !n3n[SW+2];
  end

  logic [NW-1:0] w1_q, w2_q, w3_q, den4_q;
  logic          in4_q;
  always_ff @(posedge clk_i) begin
    w1_q   <= n1n[NW-1:0];
    w2_q   <= n2n[NW-1:0];
    w3_q   <= n3n[NW-1:0];
    den4_q <= dn[NW-1:0];
    in4_q  <= in_d;
  end

  // Stage 5: weight times channel, nine products
  logic [MW-1:0] m_q [3][3];
  logic [NW-1:0] den5_q;
  logic          in5_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      m_q[k][0] <= w1_q * ca_q[COLOR_W-1-CHAN_W*k -: CHAN_W];
      m_q[k][1] <= w2_q * cb_q[COLOR_W-1-CHAN_W*k -: CHAN_W];
      m_q[k][2] <= w3_q * cc_q[COLOR_W-1-CHAN_W*k -: CHAN_W];
    end
    den5_q <= den4_q;
    in5_q  <= in4_q;
  end

  // Stage 6 and divider: remainder, quotient, denominator per step
  logic [RW-1:0]     rem_q [DIV_STEPS+1][3];
  logic [CHAN_W-1:0] quo_q [DIV_STEPS+1][3];
  logic [NW-1:0]     dv_q  [DIV_STEPS+1];
  logic              in_q  [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      rem_q[0][k] <= RW'(m_q[k][0]) + RW'(m_q[k][1]) + RW'(m_q[k][2]);
      quo_q[0][k] <= '0;
    end
    dv_q[0] <= den5_q;
    in_q[0] <= in5_q;
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
    logic [RW-1:0] trial;
    assign trial = RW'(dv_q[s-1]) << (DIV_STEPS - s);
    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 3; k++) begin
        if (rem_q[s-1][k] >= trial) begin
          rem_q[s][k] <= rem_q[s-1][k] - trial;
          quo_q[s][k] <= {quo_q[s-1][k][CHAN_W-2:0], 1'b1};
        end else begin
          rem_q[s][k] <= rem_q[s-1][k];
          quo_q[s][k] <= {quo_q[s-1][k][CHAN_W-2:0], 1'b0};
        end
      end
      dv_q[s] <= dv_q[s-1];
      in_q[s] <= in_q[s-1];
    end
  end

  // Output register: white when outside or degenerate
  logic [CHAN_W-1:0] red_q, green_q, blue_q;
  logic              inside_q;
  always_ff @(posedge clk_i) begin
    red_q    <= in_q[DIV_STEPS] ? quo_q[DIV_STEPS][0] : CHAN_WHITE;
    green_q  <= in_q[DIV_STEPS] ? quo_q[DIV_STEPS][1] : CHAN_WHITE;
    blue_q   <= in_q[DIV_STEPS] ? quo_q[DIV_STEPS][2] : CHAN_WHITE;
    inside_q <= in_q[DIV_STEPS];
  end

  assign valid_o      = vld_q[PIPE_DEPTH-1];
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign inside_res_o = inside_q;

endmodule

@@ src/bts_checker.sv @@
module bts_checker
  import bts_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              valid_o,
  input logic [CHAN_W-1:0] red_o,
  input logic [CHAN_W-1:0] green_o,
  input logic [CHAN_W-1:0] blue_o,
  input logic              inside_res_o
);

  logic [4:0] since_q;

  // Count cycles since reset, saturate at the pipeline depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_q <= '0;
    end else if (since_q != 5'(PIPE_DEPTH)) begin
      since_q <= since_q + 5'd1;
    end
  end

  // Each transfer yields exactly one result, matched to the transfer history
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    since_q == 5'(PIPE_DEPTH) |->
      valid_o == $past(start_i && !busy_o, PIPE_DEPTH))
    else $error("result strobe does not match transfer history");

  // No result before any transfer could have come through
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    since_q != 5'(PIPE_DEPTH) |-> !valid_o)
    else $error("result strobe too early after reset");

  // Outside pixels are white
  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !inside_res_o |->
      red_o == CHAN_WHITE && green_o == CHAN_WHITE && blue_o == CHAN_WHITE)
    else $error("outside pixel is not white");

  // The unit never holds off a transfer
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

endmodule

bind barycentric_triangle_shader_unit bts_checker u_bts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .valid_o      (valid_o),
  .red_o        (red_o),
  .green_o      (green_o),
  .blue_o       (blue_o),
  .inside_res_o (inside_res_o)
);
